// ===== hdl/cdcs_pkg.sv =====
// cdcs_pkg: shared types, widths and the sigmoid table for the causal
// depthwise convolution with silu block
// no dependencies
`timescale 1ns / 1ps

package cdcs_pkg;

	localparam int CHANNELS_DEF = 64;
	localparam int KERNEL_DEF   = 4;

	localparam int VAL_W   = 16;
	localparam int CHAN_W  = 6;
	localparam int TAPF_W  = 2;
	localparam int ACC_W   = 37;
	localparam int SUM_W   = 24;
	localparam int SIG_N   = 1024;
	localparam int SIG_C   = 512;
	localparam int IDX_W   = 10;
	localparam int PROD_W  = SUM_W + VAL_W + 1;

	typedef enum logic [1:0] {
		ACT_WEIGHT = 2'd0,
		ACT_BIAS   = 2'd1,
		ACT_PUSH   = 2'd2,
		ACT_CLEAR  = 2'd3
	} act_t;

	typedef struct packed {
		logic wr_weight;
		logic wr_bias;
		logic latch;
		logic clr_step;
		logic clr_bias;
		logic rd;
		logic mac;
		logic rnd;
		logic lut;
		logic mul;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		act_t action;
		logic ch_ok;
		logic tap_ok;
		logic clr_last;
		logic tap_last;
	} sts_t;

	typedef logic [15:0] sig_rom_t [SIG_N];

	// restoring long division, only used while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		int i;
		rem = '0;
		quo = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// sigmoid in q0.16 over [-8,8) at 1/64 steps, built at elaboration
	function automatic sig_rom_t build_sig_rom();
		sig_rom_t tab;
		logic [63:0] term;
		logic [63:0] r62;
		logic [63:0] r32;
		logic [63:0] e;
		logic [63:0] d;
		int n;
		int k;
		term = 64'd1 << 62;
		r62  = term;
		for (n = 1; n < 20; n++) begin
			term = udiv64(term, 64'(64 * n));
			if ((n & 1) != 0)
				r62 = r62 - term;
			else
				r62 = r62 + term;
		end
		r32 = (r62 + (64'd1 << 29)) >> 30;
		e   = 64'd1 << 32;
		for (k = 0; k <= SIG_C; k++) begin
			d = (64'd1 << 32) + e;
			if (k < SIG_C)
				tab[SIG_C + k] = 16'(udiv64((64'd1 << 48) + (d >> 1), d));
			if (k > 0)
				tab[SIG_C - k] = 16'(udiv64((e << 16) + (d >> 1), d));
			e = (e * r32 + (64'd1 << 31)) >> 32;
		end
		return tab;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== hdl/cdcs_in_if.sv =====
// cdcs_in_if: valid/ready channel for the input beats (action, channel, tap, value)
// no dependencies
`timescale 1ns / 1ps

interface cdcs_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [5:0]        channel;
	logic [1:0]        tap;
	logic signed [15:0] value;

	modport source (output valid, output action, output channel, output tap,
		output value, input ready);
	modport sink (input valid, input action, input channel, input tap,
		input value, output ready);
endinterface

// ===== hdl/cdcs_out_if.sv =====
// cdcs_out_if: valid/ready channel for the result beats (out_channel, out_value)
// no dependencies
`timescale 1ns / 1ps

interface cdcs_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         out_channel;
	logic signed [15:0] out_value;

	modport source (output valid, output out_channel, output out_value, input ready);
	modport sink (input valid, input out_channel, input out_value, output ready);
endinterface

// ===== hdl/causal_depthwise_conv_silu.sv =====
// causal_depthwise_conv_silu: a push takes one tap a cycle plus five steps: read, round,
// lookup, multiply and a load that waits for a free result register; ready stays low until
// the load; weight and bias writes keep ready high; a history clear keeps it low over
// every channel; reset is asynchronous, active low; after reset a pass over every channel
// clears the bias and history memories with ready low; weights are undefined until written
// depends on cdcs_pkg, cdcs_in_if, cdcs_out_if, cdcs_ctrl, cdcs_datapath
`timescale 1ns / 1ps

module causal_depthwise_conv_silu #(
	parameter int CHANNELS = cdcs_pkg::CHANNELS_DEF,
	parameter int KERNEL   = cdcs_pkg::KERNEL_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cdcs_in_if.sink    data_in,
	cdcs_out_if.source data_out
);
	import cdcs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cdcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (data_in.valid),
		.in_ready  (data_in.ready),
		.out_ready (data_out.ready),
		.out_valid (data_out.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	cdcs_datapath #(
		.CHANNELS (CHANNELS),
		.KERNEL   (KERNEL)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (data_in.action),
		.channel     (data_in.channel),
		.tap         (data_in.tap),
		.value       (data_in.value),
		.out_channel (data_out.out_channel),
		.out_value   (data_out.out_value)
	);

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!data_out.valid || data_out.ready))
		else $error("result register overwritten");

	// once a push is latched the input is not ready
	a_push_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> !data_in.ready)
		else $error("input taken during a push");

	// accumulation always starts right after the memory read
	a_mac_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mac && !$past(cmd.mac)) |-> $past(cmd.rd))
		else $error("accumulation without read");

endmodule

// ===== hdl/cdcs_ctrl.sv =====
// cdcs_ctrl: controller state machine, sequences clearing, memory read, tap accumulation,
// rounding, table lookup, multiply and output load; depends on cdcs_pkg
`timescale 1ns / 1ps

module cdcs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	input  cdcs_pkg::sts_t sts,
	output cdcs_pkg::cmd_t cmd
);
	import cdcs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR,
		ST_RD,
		ST_MAC,
		ST_RND,
		ST_LUT,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   bias_clr_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.wr_weight = accept && sts.action == ACT_WEIGHT && sts.ch_ok && sts.tap_ok;
				cmd.wr_bias   = accept && sts.action == ACT_BIAS && sts.ch_ok;
				cmd.latch     = accept && sts.action == ACT_PUSH && sts.ch_ok;
			end
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				cmd.clr_bias = bias_clr_q;
			end
			ST_RD:  cmd.rd  = 1'b1;
			ST_MAC: cmd.mac = 1'b1;
			ST_RND: cmd.rnd = 1'b1;
			ST_LUT: cmd.lut = 1'b1;
			ST_MUL: cmd.mul = 1'b1;
			ST_FIN: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			bias_clr_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && sts.action == ACT_CLEAR)
						state_q <= ST_CLR;
					else if (cmd.latch)
						state_q <= ST_RD;
				end
				ST_CLR: begin
					if (sts.clr_last) begin
						state_q    <= ST_IDLE;
						bias_clr_q <= 1'b0;
					end
				end
				ST_RD:  state_q <= ST_MAC;
				ST_MAC: begin
					if (sts.tap_last)
						state_q <= ST_RND;
				end
				ST_RND: state_q <= ST_LUT;
				ST_LUT: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/cdcs_datapath.sv =====
// cdcs_datapath: weight, bias and history memories, multiply-accumulate,
// rounding, sigmoid lookup, product and output register; depends on cdcs_pkg
`timescale 1ns / 1ps

module cdcs_datapath #(
	parameter int CHANNELS = cdcs_pkg::CHANNELS_DEF,
	parameter int KERNEL   = cdcs_pkg::KERNEL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cdcs_pkg::cmd_t     cmd,
	output cdcs_pkg::sts_t     sts,
	input  logic [1:0]         action,
	input  logic [5:0]         channel,
	input  logic [1:0]         tap,
	input  logic signed [15:0] value,
	output logic [5:0]         out_channel,
	output logic signed [15:0] out_value
);
	import cdcs_pkg::*;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WD     = CHANNELS * KERNEL;
	localparam int WA_W   = (WD > 1) ? $clog2(WD) : 1;
	localparam int TAP_W  = (KERNEL > 1) ? $clog2(KERNEL) : 1;
	localparam int HIST_N = (KERNEL > 1) ? KERNEL - 1 : 1;
	localparam int HW     = HIST_N * VAL_W;

	logic signed [VAL_W-1:0] w_mem [WD];
	logic signed [VAL_W-1:0] bias_mem [CHANNELS];
	logic [HW-1:0]           hist_mem [CHANNELS];

	logic [CH_W-1:0]         in_ch;
	logic [CH_W-1:0]         ch_addr;
	logic [CH_W-1:0]         clr_cnt_q;
	logic [TAP_W-1:0]        tap_cnt_q;
	logic [CHAN_W-1:0]       ch_q;
	logic signed [VAL_W-1:0] value_q;
	logic [WA_W-1:0]         w_wr_addr;
	logic [WA_W-1:0]         w_rd_addr;
	int                      rd_tap;
	logic signed [VAL_W-1:0] w_rd_q;
	logic signed [VAL_W-1:0] bias_rd_q;
	logic [HW-1:0]           hist_rd_q;
	logic [HW-1:0]           hist_shift;
	logic                    bias_we;
	logic [CH_W-1:0]         bias_wa;
	logic signed [VAL_W-1:0] bias_wd;
	logic                    hist_we;
	logic [CH_W-1:0]         hist_wa;
	logic [HW-1:0]           hist_wd;
	logic signed [VAL_W-1:0] sample;
	logic signed [31:0]      prod;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rsum;
	logic signed [SUM_W-1:0] s_next;
	logic signed [SUM_W-7:0] s_div;
	logic [IDX_W-1:0]        idx_next;
	logic signed [SUM_W-1:0] s_q;
	logic [IDX_W-1:0]        idx_q;
	logic [VAL_W-1:0]        entry_q;
	logic signed [PROD_W-1:0] p_q;
	logic signed [PROD_W-1:0] p_rnd;
	logic signed [PROD_W-17:0] o_full;
	logic [CHAN_W-1:0]       out_channel_q;
	logic signed [VAL_W-1:0] out_value_q;

	assign in_ch   = CH_W'(channel);
	assign ch_addr = CH_W'(ch_q);

	assign sts.action   = act_t'(action);
	assign sts.ch_ok    = int'(channel) < CHANNELS;
	assign sts.tap_ok   = int'(tap) < KERNEL;
	assign sts.clr_last = clr_cnt_q == CH_W'(CHANNELS - 1);
	assign sts.tap_last = tap_cnt_q == TAP_W'(KERNEL - 1);

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			tap_cnt_q <= '0;
		end else begin
			if (cmd.clr_step)
				clr_cnt_q <= sts.clr_last ? '0 : clr_cnt_q + 1'b1;
			if (cmd.rd)
				tap_cnt_q <= '0;
			else if (cmd.mac && !sts.tap_last)
				tap_cnt_q <= tap_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			ch_q    <= channel;
			value_q <= value;
		end
	end

	// weight memory, one tap per word
	assign w_wr_addr = WA_W'(int'(in_ch) * KERNEL + int'(tap));
	assign rd_tap    = (cmd.mac && !sts.tap_last) ? int'(tap_cnt_q) + 1 : 0;
	assign w_rd_addr = WA_W'(int'(ch_addr) * KERNEL + rd_tap);

	always_ff @(posedge clk) begin
		if (cmd.wr_weight)
			w_mem[w_wr_addr] <= value;
		w_rd_q <= w_mem[w_rd_addr];
	end

	// bias memory
	assign bias_we = cmd.wr_bias || (cmd.clr_step && cmd.clr_bias);
	assign bias_wa = cmd.wr_bias ? in_ch : clr_cnt_q;
	assign bias_wd = cmd.wr_bias ? value : '0;

	always_ff @(posedge clk) begin
		if (bias_we)
			bias_mem[bias_wa] <= bias_wd;
		if (cmd.rd)
			bias_rd_q <= bias_mem[ch_addr];
	end

	// history memory, one channel per row, oldest sample in the low bits
	assign hist_shift = HW'({value_q, hist_rd_q} >> VAL_W);
	assign hist_we    = cmd.clr_step || (cmd.mac && tap_cnt_q == '0);
	assign hist_wa    = cmd.clr_step ? clr_cnt_q : ch_addr;
	assign hist_wd    = cmd.clr_step ? '0 : hist_shift;

	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[hist_wa] <= hist_wd;
		if (cmd.rd)
			hist_rd_q <= hist_mem[ch_addr];
	end

	// multiply-accumulate, one tap a cycle
	assign sample   = (int'(tap_cnt_q) < KERNEL - 1)
		? hist_rd_q[int'(tap_cnt_q) * VAL_W +: VAL_W] : value_q;
	assign prod     = w_rd_q * sample;
	assign acc_base = (tap_cnt_q == '0) ? (ACC_W'(bias_rd_q) <<< 12) : acc_q;

	always_ff @(posedge clk) begin
		if (cmd.mac)
			acc_q <= acc_base + ACC_W'(prod);
	end

	// round half-up to q.12, saturate, table index
	assign rsum = (acc_q + ACC_W'(2048)) >>> 12;

	always_comb begin
		if (rsum > ACC_W'((1 << (SUM_W - 1)) - 1))
			s_next = {1'b0, {(SUM_W - 1){1'b1}}};
		else if (rsum < -(ACC_W'(1 << (SUM_W - 1))))
			s_next = {1'b1, {(SUM_W - 1){1'b0}}};
		else
			s_next = SUM_W'(rsum);
		s_div = s_next[SUM_W-1:6];
		if (s_div > (SUM_W - 6)'(SIG_C - 1))
			idx_next = IDX_W'(SIG_N - 1);
		else if (s_div < -((SUM_W - 6)'(SIG_C)))
			idx_next = '0;
		else
			idx_next = IDX_W'(s_div + (SUM_W - 6)'(SIG_C));
	end

	always_ff @(posedge clk) begin
		if (cmd.rnd) begin
			s_q   <= s_next;
			idx_q <= idx_next;
		end
		if (cmd.lut)
			entry_q <= SIG_ROM[idx_q];
		if (cmd.mul)
			p_q <= PROD_W'(s_q) * $signed({1'b0, entry_q});
	end

	// round and saturate the product
	assign p_rnd  = p_q + PROD_W'(1 << 15);
	assign o_full = p_rnd[PROD_W-1:16];

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_channel_q <= ch_q;
			if (o_full > (PROD_W - 16)'(32767))
				out_value_q <= 16'sh7fff;
			else if (o_full < -((PROD_W - 16)'(32768)))
				out_value_q <= -16'sh8000;
			else
				out_value_q <= VAL_W'(o_full);
		end
	end

	assign out_channel = out_channel_q;
	assign out_value   = out_value_q;

endmodule
